// File: rtl/lef_pkg.sv
// lef_pkg: shared widths, register and action codes, and beat types for the
// four-neighbour laplacian edge filter. No dependencies.
`timescale 1ns / 1ps

package lef_pkg;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [COL_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 13'd480;

  // signed working width of the kernel sum, range -1020..1020
  localparam int SUM_W = 12;
  localparam logic [SUM_W-1:0] SAT_LIMIT = 12'd255;

  localparam int QUEUE_DEPTH = 3;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel;
  } lef_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             last_of_frame;
  } lef_out_t;

  // one beat in the compute stage, with its memory read already in flight
  typedef struct packed {
    logic             valid;
    logic             drain;
    logic             has_result;
    logic             last;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
    logic             use_upper;
    logic             use_left;
    logic             use_right;
    logic             fwd_centre;
    logic             fwd_right;
  } lef_stage_t;

endpackage

// File: rtl/laplacian_edge_filter_core.sv
// laplacian_edge_filter_core: top level of the four-neighbour laplacian filter.
// Depends on lef_pkg, lef_seq, lef_line_store, lef_kernel, lef_out_queue.
`timescale 1ns / 1ps

// Takes one 8-bit gray pixel beat per clock in raster order while in_ready is
// high and returns |up + down + left + right - 4*centre|, saturated at 255, with
// neighbours outside the frame taken as zero. Results lag the input by one row:
// the result for a pixel leaves when the pixel below it is pushed, and after the
// frame's last pixel one drain beat per pixel releases the final row, the last
// result carrying last_of_frame. Sustained rate is one beat per cycle while
// in_ready is high; a beat sits in the stage register for the line store reads
// (centre row at two columns, upper row at one, one write each), then its
// result enters the three-entry result queue. in_ready counts the staged beat
// against that queue, so input keeps flowing, whatever out_ready does, while
// fewer than three results are queued or staged. The line stores have no reset
// and need no clearing pass. The user writes configuration (index 0 image_width,
// index 1 image_height) only while idle; the block does not enforce it.
module laplacian_edge_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lef_pkg::lef_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lef_pkg::lef_out_t              out_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  lef_pkg::lef_stage_t       stage;
  logic [ADDR_W-1:0]         rd_centre_addr;
  logic [ADDR_W-1:0]         rd_right_addr;
  logic [lef_pkg::PIX_W-1:0] rd_centre;
  logic [lef_pkg::PIX_W-1:0] rd_right;
  logic [lef_pkg::PIX_W-1:0] rd_upper;
  logic                      wr_en;
  logic [lef_pkg::PIX_W-1:0] wr_centre_data;
  logic [lef_pkg::PIX_W-1:0] wr_upper_data;
  logic                      res_valid;
  lef_pkg::lef_out_t         res_data;
  logic [lef_pkg::QCNT_W-1:0] q_count;

  lef_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .q_count        (q_count),
    .stage          (stage),
    .rd_centre_addr (rd_centre_addr),
    .rd_right_addr  (rd_right_addr)
  );

  // upper row is read at the same column as the centre
  lef_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk            (clk),
    .wr_en          (wr_en),
    .wr_addr        (ADDR_W'(stage.col)),
    .wr_centre_data (wr_centre_data),
    .wr_upper_data  (wr_upper_data),
    .rd_centre_addr (rd_centre_addr),
    .rd_right_addr  (rd_right_addr),
    .rd_upper_addr  (rd_centre_addr),
    .rd_centre      (rd_centre),
    .rd_right       (rd_right),
    .rd_upper       (rd_upper)
  );

  lef_kernel u_kernel (
    .clk            (clk),
    .stage          (stage),
    .rd_centre      (rd_centre),
    .rd_right       (rd_right),
    .rd_upper       (rd_upper),
    .wr_en          (wr_en),
    .wr_centre_data (wr_centre_data),
    .wr_upper_data  (wr_upper_data),
    .res_valid      (res_valid),
    .res_data       (res_data)
  );

  lef_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

endmodule

// File: rtl/lef_line_store.sv
// lef_line_store: the centre-row and upper-row line memories, one write port
// each, two registered reads on the centre row and one on the upper row.
// Depends on lef_pkg.
`timescale 1ns / 1ps

module lef_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [lef_pkg::PIX_W-1:0] wr_centre_data,
  input  logic [lef_pkg::PIX_W-1:0] wr_upper_data,
  input  logic [ADDR_W-1:0]         rd_centre_addr,
  input  logic [ADDR_W-1:0]         rd_right_addr,
  input  logic [ADDR_W-1:0]         rd_upper_addr,
  output logic [lef_pkg::PIX_W-1:0] rd_centre,
  output logic [lef_pkg::PIX_W-1:0] rd_right,
  output logic [lef_pkg::PIX_W-1:0] rd_upper
);

  logic [lef_pkg::PIX_W-1:0] centre_mem [DEPTH];
  logic [lef_pkg::PIX_W-1:0] upper_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      centre_mem[wr_addr] <= wr_centre_data;
    end
    rd_centre <= centre_mem[rd_centre_addr];
    rd_right  <= centre_mem[rd_right_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_upper_data;
    end
    rd_upper <= upper_mem[rd_upper_addr];
  end

endmodule

// File: rtl/lef_seq.sv
// lef_seq: configuration registers, raster position counters, beat decode and
// read issue into the line stores, with forwarding flags for back-to-back beats.
// Depends on lef_pkg.
`timescale 1ns / 1ps

module lef_seq #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lef_pkg::lef_in_t              in_data,
  input  logic [lef_pkg::QCNT_W-1:0]    q_count,
  output lef_pkg::lef_stage_t           stage,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_centre_addr,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_right_addr
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = lef_pkg::COL_W;
  localparam int ROW_W  = lef_pkg::ROW_W;

  logic [COL_W-1:0] image_width;
  logic [ROW_W-1:0] image_height;
  logic [COL_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;

  logic [COL_W-1:0] input_column, input_column_next;
  logic [ROW_W-1:0] input_row, input_row_next;
  logic [COL_W-1:0] output_column, output_column_next;

  logic             accept;
  logic             drain_state;
  logic             do_push;
  logic             do_drain;
  logic             at_end;
  logic             wr_live;
  logic [COL_W-1:0] col_sel;
  logic [COL_W:0]   col_inc;
  logic [lef_pkg::QCNT_W:0] credit_used;
  lef_pkg::lef_stage_t stage_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lef_pkg::WIDTH_RESET;
      image_height <= lef_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lef_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[COL_W-1:0];
        lef_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      eff_w = COL_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height == '0) ? ROW_W'(1) : image_height;
  end

  // the output queue holds three beats, so ready never looks at out_ready
  assign credit_used = {1'b0, q_count} + {{lef_pkg::QCNT_W{1'b0}}, stage.valid};
  assign in_ready    = credit_used < (lef_pkg::QCNT_W + 1)'(lef_pkg::QUEUE_DEPTH);

  assign accept      = in_valid && in_ready;
  assign drain_state = input_row >= eff_h;
  assign do_push     = accept && !drain_state && (in_data.action == lef_pkg::ACT_PUSH);
  assign do_drain    = accept && drain_state && (in_data.action == lef_pkg::ACT_DRAIN);
  assign col_sel     = drain_state ? output_column : input_column;
  assign col_inc     = {1'b0, col_sel} + (COL_W + 1)'(1);
  assign at_end      = col_inc >= {1'b0, eff_w};

  always_comb begin
    input_column_next  = input_column;
    input_row_next     = input_row;
    output_column_next = output_column;
    if (do_drain) begin
      if (at_end) begin
        input_column_next  = '0;
        input_row_next     = '0;
        output_column_next = '0;
      end else begin
        output_column_next = col_inc[COL_W-1:0];
      end
    end
    if (do_push) begin
      if (at_end) begin
        input_column_next = '0;
        input_row_next    = input_row + ROW_W'(1);
      end else begin
        input_column_next = col_inc[COL_W-1:0];
      end
      output_column_next = (input_row_next >= eff_h) ? '0 : input_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column  <= '0;
      input_row     <= '0;
      output_column <= '0;
    end else begin
      input_column  <= input_column_next;
      input_row     <= input_row_next;
      output_column <= output_column_next;
    end
  end

  // a push in the stage writes its column at the edge this beat reads
  assign wr_live = stage.valid && !stage.drain;

  always_comb begin
    stage_next.valid      = do_push || do_drain;
    stage_next.drain      = do_drain;
    stage_next.has_result = do_drain || (do_push && (input_row != '0));
    stage_next.last       = do_drain && at_end;
    stage_next.col        = col_sel;
    stage_next.pixel      = in_data.pixel;
    stage_next.use_upper  = drain_state ? (eff_h > ROW_W'(1)) : (input_row > ROW_W'(1));
    stage_next.use_left   = col_sel != '0;
    stage_next.use_right  = !at_end;
    stage_next.fwd_centre = wr_live && (stage.col == col_sel);
    stage_next.fwd_right  = wr_live && ({1'b0, stage.col} == col_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

  assign rd_centre_addr = ADDR_W'(col_sel);
  assign rd_right_addr  = ADDR_W'(col_inc);

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (do_drain && at_end) |=>
      (input_row == '0 && input_column == '0 && output_column == '0))
    else $error("counters not cleared after the final drain beat");

  a_fwd_after_push: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && (stage.fwd_centre || stage.fwd_right)) |->
      $past(stage.valid && !stage.drain))
    else $error("forwarding without a push in the previous cycle");

  a_column_in_store: assert property (@(posedge clk) disable iff (rst)
    (32'(input_column) < MAX_WIDTH) && (32'(output_column) < MAX_WIDTH))
    else $error("column counter beyond line store depth");

endmodule

// File: rtl/lef_kernel.sv
// lef_kernel: forwarding muxes, the four-neighbour sum, magnitude and
// saturation, and the write-back data for the line stores.
// Depends on lef_pkg.
`timescale 1ns / 1ps

module lef_kernel (
  input  logic                      clk,
  input  lef_pkg::lef_stage_t       stage,
  input  logic [lef_pkg::PIX_W-1:0] rd_centre,
  input  logic [lef_pkg::PIX_W-1:0] rd_right,
  input  logic [lef_pkg::PIX_W-1:0] rd_upper,
  output logic                      wr_en,
  output logic [lef_pkg::PIX_W-1:0] wr_centre_data,
  output logic [lef_pkg::PIX_W-1:0] wr_upper_data,
  output logic                      res_valid,
  output lef_pkg::lef_out_t         res_data
);

  localparam int PIX_W = lef_pkg::PIX_W;
  localparam int SUM_W = lef_pkg::SUM_W;

  // left_pix: last pushed pixel, or the centre of the last drain beat
  // prev_above: the value moved into the upper row by the last push
  logic [PIX_W-1:0] left_pix;
  logic [PIX_W-1:0] prev_above;

  logic [PIX_W-1:0] centre;
  logic [PIX_W-1:0] right;
  logic [PIX_W-1:0] upper;
  logic [PIX_W-1:0] self_term;
  logic [PIX_W-1:0] up_term;
  logic [PIX_W-1:0] left_term;
  logic [PIX_W-1:0] right_term;
  logic [SUM_W-1:0] pos_sum;
  logic [SUM_W-1:0] centre_x4;
  logic [SUM_W-1:0] diff;
  logic [SUM_W-1:0] mag;

  assign centre = stage.fwd_centre ? left_pix   : rd_centre;
  assign right  = stage.fwd_right  ? left_pix   : rd_right;
  assign upper  = stage.fwd_centre ? prev_above : rd_upper;

  always_comb begin
    self_term  = stage.drain ? '0 : stage.pixel;
    up_term    = stage.use_upper ? upper : '0;
    right_term = stage.use_right ? right : '0;
    if (!stage.use_left) begin
      left_term = '0;
    end else if (stage.drain) begin
      left_term = left_pix;
    end else begin
      left_term = prev_above;
    end
  end

  assign pos_sum   = SUM_W'(self_term) + SUM_W'(up_term) + SUM_W'(left_term)
                   + SUM_W'(right_term);
  assign centre_x4 = SUM_W'({centre, 2'b00});
  assign diff      = pos_sum - centre_x4;
  assign mag       = diff[SUM_W-1] ? (~diff + SUM_W'(1)) : diff;

  always_ff @(posedge clk) begin
    if (stage.valid) begin
      if (stage.drain) begin
        left_pix <= centre;
      end else begin
        left_pix   <= stage.pixel;
        prev_above <= centre;
      end
    end
  end

  assign wr_en          = stage.valid && !stage.drain;
  assign wr_centre_data = stage.pixel;
  assign wr_upper_data  = centre;

  assign res_valid              = stage.valid && stage.has_result;
  assign res_data.edge_value    = (mag > lef_pkg::SAT_LIMIT) ?
                                  lef_pkg::SAT_LIMIT[PIX_W-1:0] : mag[PIX_W-1:0];
  assign res_data.last_of_frame = stage.last;

endmodule

// File: rtl/lef_out_queue.sv
// lef_out_queue: three-entry result queue that decouples the output
// handshake from input acceptance. Depends on lef_pkg.
`timescale 1ns / 1ps

module lef_out_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  lef_pkg::lef_out_t          push_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lef_pkg::lef_out_t          out_data,
  output logic [lef_pkg::QCNT_W-1:0] count
);

  localparam int QCNT_W = lef_pkg::QCNT_W;
  localparam logic [QCNT_W-1:0] LAST_SLOT = QCNT_W'(lef_pkg::QUEUE_DEPTH - 1);

  lef_pkg::lef_out_t slot [lef_pkg::QUEUE_DEPTH];
  logic [QCNT_W-1:0] head;
  logic [QCNT_W-1:0] tail;
  logic              pop;

  assign out_valid = count != '0;
  assign out_data  = slot[head];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + QCNT_W'(1);
      end
      if (pop) begin
        head <= (head == LAST_SLOT) ? '0 : head + QCNT_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count != QCNT_W'(lef_pkg::QUEUE_DEPTH)))
    else $error("result beat written into a full queue");

endmodule

// File: tb/lef_edge_checker.sv
// lef_edge_checker: watches the config, pixel and result channels of the laplacian edge
// filter, predicts every result beat and compares it with what the block returns.
// Depends on lef_pkg.
`timescale 1ns / 1ps

module lef_edge_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  lef_pkg::lef_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  lef_pkg::lef_out_t              out_data,
  output int unsigned                    fail_count,
  output int unsigned                    outstanding
);

  localparam int PIX_W = lef_pkg::PIX_W;
  localparam int COL_W = lef_pkg::COL_W;
  localparam int ROW_W = lef_pkg::ROW_W;

  logic [PIX_W-1:0]  upper_row [MAX_WIDTH];
  logic [PIX_W-1:0]  centre_row [MAX_WIDTH];
  logic [COL_W-1:0]  width_reg;
  logic [ROW_W-1:0]  height_reg;
  int unsigned       in_col;
  int unsigned       in_row;
  int unsigned       drain_col;
  int unsigned       mismatches = 0;
  lef_pkg::lef_out_t pending_edges[$];

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i]  = '0;
      centre_row[i] = '0;
    end
  end

  function automatic logic [PIX_W-1:0] saturate_abs(input int sum);
    int mag;
    mag = (sum < 0) ? -sum : sum;
    if (mag > int'(lef_pkg::SAT_LIMIT)) mag = int'(lef_pkg::SAT_LIMIT);
    return mag[PIX_W-1:0];
  endfunction

  task automatic predict_laplacian(input lef_pkg::lef_in_t beat);
    int unsigned       w;
    int unsigned       h;
    int unsigned       c;
    int unsigned       r;
    int                sum;
    logic [PIX_W-1:0]  above;
    logic [PIX_W-1:0]  upper_old;
    lef_pkg::lef_out_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    if (in_row >= h) begin
      // frame complete: drains release the bottom row, pushes are dropped
      if (beat.action == lef_pkg::ACT_DRAIN) begin
        c   = drain_col;
        sum = -4 * int'(centre_row[c]);
        if (h >= 2) sum += int'(upper_row[c]);
        if (c >= 1) sum += int'(centre_row[c-1]);
        if (c + 1 < w) sum += int'(centre_row[c+1]);
        res.edge_value    = saturate_abs(sum);
        res.last_of_frame = (c + 1 >= w);
        pending_edges = {pending_edges, res};
        if (res.last_of_frame) begin
          in_col    = 0;
          in_row    = 0;
          drain_col = 0;
        end else begin
          drain_col = c + 1;
        end
      end
    end else if (beat.action == lef_pkg::ACT_PUSH) begin
      c         = in_col;
      r         = in_row;
      above     = centre_row[c];
      upper_old = upper_row[c];
      upper_row[c]  = above;
      centre_row[c] = beat.pixel;
      if (r >= 1) begin
        // result for the pixel above; its left neighbour has moved to the upper store
        sum = int'(beat.pixel) - 4 * int'(above);
        if (r >= 2) sum += int'(upper_old);
        if (c >= 1) sum += int'(upper_row[c-1]);
        if (c + 1 < w) sum += int'(centre_row[c+1]);
        res.edge_value    = saturate_abs(sum);
        res.last_of_frame = 1'b0;
        pending_edges = {pending_edges, res};
      end
      if (c + 1 >= w) begin
        in_col = 0;
        in_row = r + 1;
      end else begin
        in_col = c + 1;
      end
      drain_col = (in_row >= h) ? 0 : in_col;
    end
  endtask

  task automatic check_edge(input lef_pkg::lef_out_t got);
    lef_pkg::lef_out_t want;
    if (pending_edges.size() == 0) begin
      $display("%0t: unexpected result beat, edge_value %0d last_of_frame %0b",
               $time, got.edge_value, got.last_of_frame);
      mismatches++;
    end else begin
      want = pending_edges.pop_front();
      if (got.edge_value !== want.edge_value) begin
        $display("%0t: edge_value expected %0d actual %0d",
                 $time, want.edge_value, got.edge_value);
        mismatches++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $display("%0t: last_of_frame expected %0b actual %0b",
                 $time, want.last_of_frame, got.last_of_frame);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = lef_pkg::WIDTH_RESET;
      height_reg = lef_pkg::HEIGHT_RESET;
      in_col     = 0;
      in_row     = 0;
      drain_col  = 0;
      pending_edges.delete();
    end else begin
      // a beat accepted at this edge still sees the old register values
      if (in_valid && in_ready) predict_laplacian(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lef_pkg::REG_IMAGE_WIDTH:  width_reg  = cfg_data[COL_W-1:0];
          lef_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_edge(out_data);
    end
    fail_count  <= mismatches;
    outstanding <= pending_edges.size();
  end

endmodule

// File: tb/laplacian_edge_filter_core_tb.sv
// laplacian_edge_filter_core_tb: drives pixel frames and register settings into the
// laplacian edge filter with bursty input and a stalling receiver, and reports the verdict.
// Depends on lef_pkg, laplacian_edge_filter_core and lef_edge_checker.
`timescale 1ns / 1ps

module laplacian_edge_filter_core_tb;

  localparam int PIX_W      = lef_pkg::PIX_W;
  localparam int COL_W      = lef_pkg::COL_W;
  localparam int CFG_IDX_W  = lef_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = lef_pkg::CFG_DATA_W;

  localparam int MAX_WIDTH     = 1024;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 900;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  lef_pkg::lef_in_t      in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_ready;
  logic                  in_ready;
  logic                  out_valid;
  lef_pkg::lef_out_t     out_data;
  int unsigned           fail_count;
  int unsigned           outstanding;

  int unsigned      cycle_count   = 0;
  int unsigned      burst_left    = 0;
  int unsigned      ready_left    = 0;
  int unsigned      rx_pick;
  int unsigned      counted_items = 0;
  int unsigned      frame_w       = 1;
  int unsigned      frame_h       = 1;
  logic [PIX_W-1:0] last_pixel    = '0;

  // 3x3 cross that saturates both ways, bottom row small enough to stay unsaturated
  logic [PIX_W-1:0] cross_image [9] = '{8'd0, 8'd255, 8'd0,
                                         8'd255, 8'd0, 8'd255,
                                         8'd10, 8'd20, 8'd30};

  laplacian_edge_filter_core #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lef_edge_checker #(.MAX_WIDTH(MAX_WIDTH)) edge_monitor (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: long open stretches, short bursts and short stalls
  always @(posedge clk) begin
    if (ready_left == 0) begin
      rx_pick = $urandom_range(0, 9);
      if (rx_pick < 2) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(50, 200);
      end else if (rx_pick < 6) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(1, 8);
      end
    end else begin
      ready_left--;
    end
  end

  function automatic logic [PIX_W-1:0] gray_level();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 255);
      1:       v = $urandom_range(0, 1) ? 255 : 0;
      default: v = int'(last_pixel) + int'($urandom_range(0, 16)) - 8;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    last_pixel = v[PIX_W-1:0];
    return last_pixel;
  endfunction

  task automatic send_beat(input logic action, input logic [PIX_W-1:0] pixel);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_data.action <= action;
    in_data.pixel  <= pixel;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait until every result is out, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata);
    settle();
    if ($urandom_range(0, 1)) begin
      write_reg(lef_pkg::REG_IMAGE_WIDTH, wdata);
      write_reg(lef_pkg::REG_IMAGE_HEIGHT, hdata);
    end else begin
      write_reg(lef_pkg::REG_IMAGE_HEIGHT, hdata);
      write_reg(lef_pkg::REG_IMAGE_WIDTH, wdata);
    end
    cfg_valid <= 1'b0;
    frame_w = wdata[COL_W-1:0];
    if (frame_w == 0) frame_w = 1;
    if (frame_w > MAX_WIDTH) frame_w = MAX_WIDTH;
    frame_h = (hdata == 0) ? 1 : hdata;
  endtask

  // one frame plus its drain row, with ignored beats sprinkled in
  task automatic run_frame();
    for (int unsigned r = 0; r < frame_h; r++) begin
      for (int unsigned c = 0; c < frame_w; c++) begin
        if ($urandom_range(0, 24) == 0) begin
          send_beat(lef_pkg::ACT_DRAIN, PIX_W'($urandom_range(0, 255)));
        end
        send_beat(lef_pkg::ACT_PUSH, gray_level());
        counted_items++;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_beat(lef_pkg::ACT_PUSH, PIX_W'($urandom_range(0, 255)));
    end
    for (int unsigned c = 0; c < frame_w; c++) begin
      if ($urandom_range(0, 24) == 0) begin
        send_beat(lef_pkg::ACT_PUSH, PIX_W'($urandom_range(0, 255)));
      end
      send_beat(lef_pkg::ACT_DRAIN, PIX_W'($urandom_range(0, 255)));
      counted_items++;
    end
    if ($urandom_range(0, 3) == 0) send_beat(lef_pkg::ACT_DRAIN, PIX_W'($urandom_range(0, 255)));
  endtask

  function automatic logic [CFG_DATA_W-1:0] width_word(input int unsigned w);
    // bits above the width field are don't-care to the block
    return CFG_DATA_W'(w) | (CFG_DATA_W'($urandom_range(0, 3)) << COL_W);
  endfunction

  task automatic random_phase();
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    pick = $urandom_range(0, 9);
    if (pick == 0) w = 0;
    else if (pick < 3) w = $urandom_range(1, 48);
    else w = $urandom_range(1, 10);
    pick = $urandom_range(0, 9);
    if (pick == 0) h = 0;
    else if (pick < 3) h = $urandom_range(1, 12);
    else h = $urandom_range(1, 5);
    configure(width_word(w), CFG_DATA_W'(h));
    repeat ($urandom_range(1, 3)) run_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    configure(13'd3, 13'd3);
    send_beat(lef_pkg::ACT_DRAIN, 8'h5A);
    for (int i = 0; i < 9; i++) begin
      if (i == 6) send_beat(lef_pkg::ACT_DRAIN, 8'hA5);
      send_beat(lef_pkg::ACT_PUSH, cross_image[i]);
    end
    send_beat(lef_pkg::ACT_PUSH, 8'hFF);
    repeat (3) send_beat(lef_pkg::ACT_DRAIN, 8'h00);
    send_beat(lef_pkg::ACT_DRAIN, 8'hFF);

    // single-row frame: both vertical neighbours outside
    configure(13'd4, 13'd1);
    send_beat(lef_pkg::ACT_PUSH, 8'd255);
    send_beat(lef_pkg::ACT_PUSH, 8'd0);
    send_beat(lef_pkg::ACT_PUSH, 8'd0);
    send_beat(lef_pkg::ACT_PUSH, 8'd255);
    repeat (4) send_beat(lef_pkg::ACT_DRAIN, 8'h00);

    while (counted_items < RANDOM_ITEMS) random_phase();

    // tall single-column frame, then a short one
    configure(width_word(1), 13'd300);
    run_frame();
    configure(width_word($urandom_range(2, 6)), CFG_DATA_W'($urandom_range(2, 4)));
    run_frame();

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
